### hw/rtl/tds_pkg.sv
// ----------------------------------------------------------------------------
// tds_pkg
// Types, constants and fixed-point helpers shared by the tridiagonal solver.
// ----------------------------------------------------------------------------
package tds_pkg;

	localparam int MaxRows   = 64;
	localparam int DataWidth = 32;
	localparam int FracBits  = 16;
	localparam int IdxWidth  = $clog2(MaxRows);
	localparam int CntWidth  = $clog2(MaxRows + 1);
	localparam int QueueDepth = 2;

	typedef logic signed [DataWidth-1:0] data_t;

	typedef struct packed {
		data_t sub_diag;
		data_t main_diag;
		data_t super_diag;
		data_t rhs_value;
		logic  last_row;
	} in_item_t;

	typedef struct packed {
		data_t               solution;
		logic [IdxWidth-1:0] row_index;
		logic                final_result;
		logic                pivot_error;
	} out_item_t;

	// Front-end classified row, handed to the back end through the queue.
	typedef struct packed {
		data_t               sub_diag;
		data_t               main_diag;
		data_t               super_diag;
		data_t               rhs_value;
		logic [IdxWidth-1:0] idx;
		logic                first;
		logic                last;
	} row_cmd_t;

	localparam logic signed [DataWidth-1:0] VMax = {1'b0, {(DataWidth-1){1'b1}}};
	localparam logic signed [DataWidth-1:0] VMin = {1'b1, {(DataWidth-1){1'b0}}};

	function automatic data_t sat_wide(input logic signed [2*DataWidth+1:0] v);
		if (v > $signed({{(DataWidth+2){1'b0}}, VMax}))
			sat_wide = VMax;
		else if (v < $signed({{(DataWidth+2){1'b1}}, VMin}))
			sat_wide = VMin;
		else
			sat_wide = v[DataWidth-1:0];
	endfunction

	// Floor shift of an exact product, then saturate.
	function automatic data_t fx_scale(input logic signed [2*DataWidth-1:0] p);
		logic signed [2*DataWidth+1:0] e;
		e = {{2{p[2*DataWidth-1]}}, p};
		fx_scale = sat_wide(e >>> FracBits);
	endfunction

	function automatic data_t sub_sat(input data_t x, input data_t y);
		logic signed [DataWidth:0] s;
		logic signed [2*DataWidth+1:0] e;
		s = {x[DataWidth-1], x} - {y[DataWidth-1], y};
		e = {{(DataWidth+1){s[DataWidth]}}, s};
		sub_sat = sat_wide(e);
	endfunction

endpackage

### hw/rtl/tds_divider.sv
// ----------------------------------------------------------------------------
// tds_divider
// Radix-2 restoring divider: (num << FracBits) / den, truncated, saturated.
// ----------------------------------------------------------------------------
module tds_divider import tds_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  data_t num,
	input  data_t den,
	output logic  done,
	output data_t quo,
	output logic  zero_den
);

	localparam int NumW = DataWidth + FracBits;
	localparam int StW  = $clog2(NumW + 1);

	logic [NumW-1:0]      dvd_q;
	logic [DataWidth-1:0] dsr_q;
	logic [DataWidth:0]   rem_q;
	logic [NumW-1:0]      quo_q;
	logic [StW-1:0]       cnt_q;
	logic                 busy_q;
	logic                 neg_q;
	logic                 zero_q;
	logic                 nneg_q;
	logic [DataWidth:0]   trial;
	logic [DataWidth+1:0] diff;
	logic signed [2*DataWidth+1:0] sq;

	assign trial = {rem_q[DataWidth-1:0], dvd_q[NumW-1]};
	assign diff  = {1'b0, trial} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= (den != '0);
				done   <= (den == '0);
			end else if (busy_q && cnt_q == StW'(NumW - 1)) begin
				busy_q <= 1'b0;
				done   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= NumW'(num[DataWidth-1] ? -{{FracBits{1'b1}}, num} : {{FracBits{1'b0}}, num})
				<< FracBits;
			dsr_q  <= den[DataWidth-1] ? DataWidth'(-den) : den;
			rem_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			neg_q  <= num[DataWidth-1] ^ den[DataWidth-1];
			zero_q <= (den == '0);
			nneg_q <= ~num[DataWidth-1];
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			cnt_q <= cnt_q + 1'b1;
			if (!diff[DataWidth+1]) begin
				rem_q <= diff[DataWidth:0];
				quo_q <= {quo_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NumW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		sq = neg_q ? -$signed({{(2*DataWidth+2-NumW){1'b0}}, quo_q})
			: $signed({{(2*DataWidth+2-NumW){1'b0}}, quo_q});
		if (zero_q)
			quo = nneg_q ? VMax : VMin;
		else
			quo = sat_wide(sq);
	end
	assign zero_den = zero_q;

endmodule

### hw/rtl/tds_front.sv
// ----------------------------------------------------------------------------
// tds_front
// Accepts rows, numbers them within the system and forces the last row.
// ----------------------------------------------------------------------------
module tds_front import tds_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	output logic     cmd_valid,
	input  logic     cmd_ready,
	output row_cmd_t cmd
);

	logic [IdxWidth-1:0] cnt_q;
	logic                full_last;

	assign full_last = (cnt_q == IdxWidth'(MaxRows - 1));
	assign in_ready  = cmd_ready;
	assign cmd_valid = in_valid;

	always_comb begin
		cmd.sub_diag   = in_data.sub_diag;
		cmd.main_diag  = in_data.main_diag;
		cmd.super_diag = in_data.super_diag;
		cmd.rhs_value  = in_data.rhs_value;
		cmd.idx        = cnt_q;
		cmd.first      = (cnt_q == '0);
		cmd.last       = in_data.last_row | full_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_valid && cmd_ready) begin
			cnt_q <= cmd.last ? '0 : cnt_q + 1'b1;
		end
	end

endmodule

### hw/rtl/tds_queue.sv
// ----------------------------------------------------------------------------
// tds_queue
// Two-entry queue between front end and back end.
// ----------------------------------------------------------------------------
module tds_queue import tds_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_valid,
	output logic     wr_ready,
	input  row_cmd_t wr_data,
	output logic     rd_valid,
	input  logic     rd_ready,
	output row_cmd_t rd_data
);

	row_cmd_t mem_q [QueueDepth];
	logic     wp_q, rp_q;
	logic [1:0] cnt_q;
	logic     wr, rd;

	assign wr_ready = (cnt_q != 2'(QueueDepth));
	assign rd_valid = (cnt_q != '0);
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

endmodule

### hw/rtl/tds_back.sv
// ----------------------------------------------------------------------------
// tds_back
// Forward elimination per row and back substitution on the last row.
// ----------------------------------------------------------------------------
module tds_back import tds_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  row_cmd_t  cmd,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_RD    = 11'b00000000010,
		S_MUL   = 11'b00000000100,
		S_SUB   = 11'b00000001000,
		S_DIVW  = 11'b00000010000,
		S_DIVG  = 11'b00000100000,
		S_BRD   = 11'b00001000000,
		S_BMUL  = 11'b00010000000,
		S_BSUB  = 11'b00100000000,
		S_EMIT  = 11'b01000000000,
		S_WAIT  = 11'b10000000000
	} state_t;

	state_t state_q;
	row_cmd_t row_q;
	data_t upper_mem [MaxRows];
	data_t rhs_mem [MaxRows];
	data_t w_rd_q, g_rd_q;
	logic signed [2*DataWidth-1:0] pw_q, pg_q;
	data_t piv_q, num_q, w_q, x_q;
	logic [IdxWidth-1:0] bidx_q;
	logic  err_q;
	logic  div_start, div_done, div_zero;
	data_t div_num, div_quo;
	logic  div_wait_q;
	logic  mem_we;
	logic [IdxWidth-1:0] mem_wa, mem_ra;
	data_t mem_wu, mem_wg;

	tds_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(piv_q),
		.done(div_done), .quo(div_quo), .zero_den(div_zero)
	);

	assign cmd_ready = (state_q == S_IDLE);
	assign div_num   = (state_q == S_DIVW) ? row_q.super_diag : num_q;
	assign div_start = ((state_q == S_DIVW) || (state_q == S_DIVG)) && !div_wait_q;
	assign mem_ra    = (state_q == S_RD) ? row_q.idx - 1'b1 : bidx_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			upper_mem[mem_wa] <= mem_wu;
			rhs_mem[mem_wa]   <= mem_wg;
		end
		w_rd_q <= upper_mem[mem_ra];
		g_rd_q <= rhs_mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			err_q      <= 1'b0;
			out_valid  <= 1'b0;
			div_wait_q <= 1'b0;
		end else begin
			if (out_valid && out_ready && state_q != S_EMIT) out_valid <= 1'b0;
			if (div_start) div_wait_q <= 1'b1;
			case (state_q)
				S_IDLE: if (cmd_valid) state_q <= cmd.first ? S_SUB : S_RD;
				S_RD:   state_q <= S_MUL;
				S_MUL:  state_q <= S_SUB;
				S_SUB:  state_q <= row_q.last ? S_DIVG : S_DIVW;
				S_DIVW: if (div_done) begin
					div_wait_q <= 1'b0;
					if (div_zero) err_q <= 1'b1;
					state_q <= S_DIVG;
				end
				S_DIVG: if (div_done) begin
					div_wait_q <= 1'b0;
					if (div_zero) err_q <= 1'b1;
					if (row_q.last) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_BRD:  state_q <= S_BMUL;
				S_BMUL: state_q <= S_BSUB;
				S_BSUB: state_q <= S_EMIT;
				S_EMIT: if (!out_valid || out_ready) begin
					out_valid <= 1'b1;
					if (bidx_q == '0) begin
						err_q   <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_BRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = row_q.idx;
		mem_wu = w_q;
		mem_wg = div_quo;
		if (state_q == S_DIVG && div_done) begin
			mem_we = 1'b1;
			mem_wu = row_q.last ? '0 : w_q;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (cmd_valid) begin
				row_q <= cmd;
				piv_q <= cmd.main_diag;
				num_q <= cmd.rhs_value;
			end
			S_MUL: begin
				pw_q <= row_q.sub_diag * w_rd_q;
				pg_q <= row_q.sub_diag * g_rd_q;
			end
			S_SUB: if (!row_q.first) begin
				piv_q <= sub_sat(row_q.main_diag, fx_scale(pw_q));
				num_q <= sub_sat(row_q.rhs_value, fx_scale(pg_q));
			end
			S_DIVW: if (div_done) w_q <= div_quo;
			S_DIVG: if (div_done) begin
				x_q    <= div_quo;
				bidx_q <= row_q.idx;
			end
			S_BMUL: pw_q <= w_rd_q * x_q;
			S_BSUB: x_q <= sub_sat(g_rd_q, fx_scale(pw_q));
			S_EMIT: if (!out_valid || out_ready) begin
				out_data.solution     <= x_q;
				out_data.row_index    <= bidx_q;
				out_data.final_result <= (bidx_q == '0);
				out_data.pivot_error  <= err_q;
				bidx_q <= bidx_q - 1'b1;
			end
			default: ;
		endcase
	end

endmodule

### hw/rtl/tridiagonal_system_solver.sv
// ----------------------------------------------------------------------------
// tridiagonal_system_solver
// A row before the last passes through fetch, multiply and subtract in the
// back end, then through two passes of the 48-step serial divider (upper
// coefficient, then right-hand side); the first row skips the fetch and
// multiply, and the last row needs only the right-hand side pass.
// The last row then emits one solution per read, multiply and subtract round
// while the output is not stalled, from the final index down to zero.
// ----------------------------------------------------------------------------
module tridiagonal_system_solver import tds_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic     f_valid, f_ready, q_valid, q_ready;
	row_cmd_t f_cmd, q_cmd;

	tds_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	tds_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(f_valid), .wr_ready(f_ready),
		.wr_data(f_cmd), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
	);

	tds_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(q_valid), .cmd_ready(q_ready),
		.cmd(q_cmd), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

endmodule

### hw/rtl/tds_checker.sv
// ----------------------------------------------------------------------------
// tds_checker
// Port-level checks for the tridiagonal solver.
// ----------------------------------------------------------------------------
module tds_checker import tds_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	logic [IdxWidth-1:0] prev_idx_q;
	logic                open_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_idx_q <= '0;
			open_q     <= 1'b0;
		end else if (out_valid && out_ready) begin
			prev_idx_q <= out_data.row_index;
			open_q     <= !out_data.final_result;
		end
	end

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input transfer withdrawn");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped while stalled");

	a_final_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.final_result |-> out_data.row_index == '0)
		else $error("final result not at index zero");

	a_idx_down: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && open_q |-> out_data.row_index == prev_idx_q - 1'b1)
		else $error("solution index not descending");

endmodule

bind tridiagonal_system_solver tds_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the tridiagonal system solver. Directed and random systems
// are streamed in row by row; a scoreboard runs the forward sweep per row and
// back substitution on the last row, and checks each emitted solution in order.
// ----------------------------------------------------------------------------
class tds_scoreboard;
	localparam longint VMAXL = 64'sd2147483647;
	localparam longint VMINL = -64'sd2147483648;

	longint upper_coef[64];
	longint mod_rhs[64];
	int unsigned rows_seen;
	bit pivot_zero;
	tds_pkg::out_item_t pending[$];
	int errors;

	function new();
		rows_seen = 0;
		pivot_zero = 0;
		errors = 0;
	endfunction

	function longint clamp(longint v);
		if (v > VMAXL) return VMAXL;
		if (v < VMINL) return VMINL;
		return v;
	endfunction

	function longint qmul(longint x, longint y);
		longint p;
		p = x * y;
		return clamp(p >>> tds_pkg::FracBits);
	endfunction

	function longint qdiv(longint num, longint den);
		if (den == 0) begin
			pivot_zero = 1;
			return (num >= 0) ? VMAXL : VMINL;
		end
		return clamp((num * 65536) / den);
	endfunction

	function void note_row(tds_pkg::in_item_t it);
		longint a, b, c, d, piv, num, x;
		int unsigned i;
		bit last;
		tds_pkg::out_item_t r;
		a = it.sub_diag;
		b = it.main_diag;
		c = it.super_diag;
		d = it.rhs_value;
		last = it.last_row;
		i = rows_seen;
		if (i >= 64) i = 63;
		if (i == 63) last = 1;
		if (i == 0) begin
			piv = b;
			num = d;
		end else begin
			piv = clamp(b - qmul(a, upper_coef[i-1]));
			num = clamp(d - qmul(a, mod_rhs[i-1]));
		end
		upper_coef[i] = last ? 0 : qdiv(c, piv);
		mod_rhs[i] = qdiv(num, piv);
		if (!last) begin
			rows_seen = i + 1;
			return;
		end
		x = mod_rhs[i];
		for (int k = 0; k <= int'(i); k++) begin
			int idx;
			idx = int'(i) - k;
			if (k > 0) x = clamp(mod_rhs[idx] - qmul(upper_coef[idx], x));
			r.solution = x[31:0];
			r.row_index = idx[5:0];
			r.final_result = (idx == 0);
			r.pivot_error = pivot_zero;
			pending.push_back(r);
		end
		rows_seen = 0;
		pivot_zero = 0;
	endfunction

	function void check_solution(tds_pkg::out_item_t got);
		tds_pkg::out_item_t want;
		if (pending.size() == 0) begin
			$display("%0t: unexpected solution %h", $time, got);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got.solution !== want.solution) begin
			$display("%0t: solution exp %h got %h", $time, want.solution, got.solution);
			errors++;
		end
		if (got.row_index !== want.row_index) begin
			$display("%0t: row_index exp %0d got %0d", $time, want.row_index,
				got.row_index);
			errors++;
		end
		if (got.final_result !== want.final_result) begin
			$display("%0t: final_result exp %b got %b", $time, want.final_result,
				got.final_result);
			errors++;
		end
		if (got.pivot_error !== want.pivot_error) begin
			$display("%0t: pivot_error exp %b got %b", $time, want.pivot_error,
				got.pivot_error);
			errors++;
		end
	endfunction
endclass

module tb_top;
	import tds_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;

	tds_scoreboard solutions;
	bit quiet;
	bit hold_off;
	longint cycles;

	tridiagonal_system_solver u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 64'd6000000) begin
				$display("** tridiagonal_system_solver: FAILED **");
				$finish;
			end
		end
	end

	function automatic data_t rand_coef();
		case ($urandom_range(0, 9))
			0: return VMax;
			1: return VMin;
			2: return '0;
			3: return data_t'($urandom_range(0, 4) << 16);
			4, 5: return data_t'($urandom);
			default: return data_t'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
		endcase
	endfunction

	function automatic data_t rand_diag();
		if ($urandom_range(0, 15) == 0) return rand_coef();
		return data_t'(int'($urandom_range(6 << 16, 40 << 16))
			* (($urandom_range(0, 1) == 1) ? 1 : -1));
	endfunction

	task automatic send_row(in_item_t it);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		solutions.note_row(it);
	endtask

	task automatic send_system(int rows, bit wild);
		in_item_t it;
		for (int r = 0; r < rows; r++) begin
			it.sub_diag = wild ? rand_coef() : data_t'(int'($urandom_range(0, 2 << 16)) - (1 << 16));
			it.main_diag = wild ? rand_coef() : rand_diag();
			it.super_diag = wild ? rand_coef() : data_t'(int'($urandom_range(0, 2 << 16)) - (1 << 16));
			it.rhs_value = rand_coef();
			it.last_row = (r == rows - 1);
			send_row(it);
		end
	endtask

	initial begin
		out_ready = 1'b0;
		hold_off = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_off = 0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10) - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) solutions.check_solution(out_data);
	end

	initial begin
		in_item_t it;
		int sent;
		int wait_cnt;
		solutions = new();
		quiet = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-row systems at the extremes, zero pivot
		it = '{sub_diag: VMax, main_diag: VMin, super_diag: VMax, rhs_value: VMax, last_row: 1'b1};
		send_row(it);
		it = '{sub_diag: VMin, main_diag: '0, super_diag: VMin, rhs_value: VMin, last_row: 1'b1};
		send_row(it);
		it = '{sub_diag: '0, main_diag: '0, super_diag: '0, rhs_value: '0, last_row: 1'b1};
		send_row(it);
		it = '{sub_diag: '1, main_diag: 32'sh0001_0000, super_diag: '1, rhs_value: '1,
			last_row: 1'b1};
		send_row(it);
		// two-row system with zero pivot in the second row
		it = '{sub_diag: 32'sh0001_0000, main_diag: 32'sh0001_0000,
			super_diag: 32'sh0001_0000, rhs_value: 32'sh0002_0000, last_row: 1'b0};
		send_row(it);
		it.last_row = 1'b1;
		send_row(it);
		send_system(3, 1);
		send_system(4, 0);
		// overlong system: row 63 closes it without last_row
		for (int r = 0; r < 64; r++) begin
			it.sub_diag = data_t'($urandom_range(0, 1 << 16));
			it.main_diag = rand_diag();
			it.super_diag = data_t'($urandom_range(0, 1 << 16));
			it.rhs_value = data_t'($urandom);
			it.last_row = 1'b0;
			send_row(it);
		end

		hold_off = 1;
		send_system(12, 0);
		send_system(6, 0);

		sent = 0;
		while (sent < 370) begin
			int rows;
			rows = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
			send_system(rows, $urandom_range(0, 5) == 0);
			sent += rows;
			if (sent > 290) quiet = 1;
		end
		in_valid <= 1'b0;

		wait_cnt = 0;
		while (solutions.pending.size() != 0 && wait_cnt < 100000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (300) @(posedge clk);
		if (solutions.errors == 0 && solutions.pending.size() == 0)
			$display("** tridiagonal_system_solver: PASSED **");
		else
			$display("** tridiagonal_system_solver: FAILED **");
		$finish;
	end
endmodule

### files.f
hw/rtl/tds_pkg.sv
hw/rtl/tds_divider.sv
hw/rtl/tds_front.sv
hw/rtl/tds_queue.sv
hw/rtl/tds_back.sv
hw/rtl/tridiagonal_system_solver.sv
hw/rtl/tds_checker.sv
tb/tb_top.sv
